>>> src/security_access_sequencer_defines.svh
// Assertion macros used by the security access sequencer engine (sas_engine).
// The macros expect a signal named clk, and SAS_ASSERT also arst_n, in the module that uses them.
`ifndef SECURITY_ACCESS_SEQUENCER_DEFINES_SVH
`define SECURITY_ACCESS_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define SAS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SAS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SAS_ASSERT(label, prop, msg)
`define SAS_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> src/sas_pkg.sv
`timescale 1ns / 1ps

package sas_pkg;

	// Command codes of an input item.
	localparam logic [1:0] CMD_REQUEST = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_SESSION = 2'd2;

	// Reply kinds.
	localparam logic [1:0] KIND_NONE     = 2'd0;
	localparam logic [1:0] KIND_POSITIVE = 2'd1;
	localparam logic [1:0] KIND_NEGATIVE = 2'd2;

	// Negative response codes.
	localparam logic [2:0] NRC_NONE     = 3'd0;
	localparam logic [2:0] NRC_LENGTH   = 3'd1;
	localparam logic [2:0] NRC_SUBFUNC  = 3'd2;
	localparam logic [2:0] NRC_DELAY    = 3'd3;
	localparam logic [2:0] NRC_SEQUENCE = 3'd4;
	localparam logic [2:0] NRC_RANGE    = 3'd5;
	localparam logic [2:0] NRC_ATTEMPTS = 3'd6;
	localparam logic [2:0] NRC_BADKEY   = 3'd7;

	// Sub-function bytes.
	localparam logic [7:0] SF_SEED_A = 8'h03;
	localparam logic [7:0] SF_KEY_A  = 8'h04;
	localparam logic [7:0] SF_SEED_B = 8'h05;
	localparam logic [7:0] SF_KEY_B  = 8'h06;
	localparam logic [7:0] SF_SEED_C = 8'h11;
	localparam logic [7:0] SF_KEY_C  = 8'h12;

	// Levels that a correct key unlocks.
	localparam logic [4:0] LVL_LOCKED = 5'd0;
	localparam logic [4:0] LVL_A      = 5'd3;
	localparam logic [4:0] LVL_B      = 5'd5;
	localparam logic [4:0] LVL_C      = 5'd17;

	// Request lengths.
	localparam logic [7:0] LEN_MIN  = 8'd2;
	localparam logic [7:0] LEN_SEED = 8'd2;
	localparam logic [7:0] LEN_KEY  = 8'd6;

	localparam logic [3:0] FAIL_MAX = 4'hF;

	// Configuration register indexes and reset values.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 2'd1;
	localparam logic [3:0]  MAX_ATTEMPTS_RST  = 4'd3;
	localparam logic [15:0] LOCKOUT_TICKS_RST = 16'd10000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  msg_length;
		logic [7:0]  sub_function;
		logic [31:0] key_received;
		logic [31:0] fresh_seed;
		logic [31:0] expected_key;
	} item_t;

	typedef struct packed {
		logic [1:0]  reply_kind;
		logic [2:0]  negative_code;
		logic [7:0]  reply_sub_function;
		logic        has_seed;
		logic [31:0] seed_out;
		logic [4:0]  unlocked_level;
	} result_t;

	typedef struct packed {
		logic [3:0]  max_attempts;
		logic [15:0] lockout_ticks;
	} cfg_t;

endpackage

>>> src/sas_cfg_regs.sv
`timescale 1ns / 1ps

module sas_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [sas_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [sas_pkg::CFG_DATA_W-1:0]       wr_data,
	output sas_pkg::cfg_t                        cfg
);

	logic [3:0]  max_attempts_q;
	logic [15:0] lockout_ticks_q;

	// Writes to indexes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_attempts_q  <= sas_pkg::MAX_ATTEMPTS_RST;
			lockout_ticks_q <= sas_pkg::LOCKOUT_TICKS_RST;
		end else if (wr_en) begin
			case (wr_index)
				sas_pkg::CFG_MAX_ATTEMPTS: begin
					max_attempts_q <= wr_data[3:0];
				end
				sas_pkg::CFG_LOCKOUT_TICKS: begin
					lockout_ticks_q <= wr_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.max_attempts  = max_attempts_q;
	assign cfg.lockout_ticks = lockout_ticks_q;

endmodule

>>> src/sas_engine.sv
`timescale 1ns / 1ps
`include "security_access_sequencer_defines.svh"

module sas_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  sas_pkg::item_t    item,
	input  sas_pkg::cfg_t     cfg,
	output sas_pkg::result_t  reply
);

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_S03,
		SEQ_K04,
		SEQ_S05,
		SEQ_K06,
		SEQ_S11,
		SEQ_K12,
		SEQ_DELAY
	} seq_t;

	seq_t        seq_q, seq_d, seq_ok;
	logic [31:0] seed_q, seed_d;
	logic [4:0]  level_q, level_d;
	logic [3:0]  fail_q, fail_d, fail_inc;
	logic        lock_q, lock_d;
	logic [15:0] remain_q, remain_d;

	logic        is_seed, is_key;
	logic [2:0]  seq_code;
	logic [7:0]  sub;

	logic        level_legal;
	logic        lock_entry_ok;
	logic        non_request;
	logic        quiet_reply;

	assign sub      = item.sub_function;
	assign is_seed  = (sub == sas_pkg::SF_SEED_A) || (sub == sas_pkg::SF_SEED_B) ||
	                  (sub == sas_pkg::SF_SEED_C);
	assign is_key   = (sub == sas_pkg::SF_KEY_A) || (sub == sas_pkg::SF_KEY_B) ||
	                  (sub == sas_pkg::SF_KEY_C);
	assign fail_inc = (fail_q == sas_pkg::FAIL_MAX) ? fail_q : fail_q + 4'd1;

	// Sequence check: the step that a passing request leads to, and the
	// negative code when it does not pass.
	always_comb begin
		seq_ok   = seq_q;
		seq_code = sas_pkg::NRC_NONE;
		if (seq_q == SEQ_DELAY) begin
			seq_code = sas_pkg::NRC_DELAY;
		end else begin
			case (sub)
				sas_pkg::SF_SEED_A: begin
					if (seq_q == SEQ_IDLE || seq_q == SEQ_S03) seq_ok = SEQ_S03;
					else seq_code = sas_pkg::NRC_SEQUENCE;
				end
				sas_pkg::SF_KEY_A: begin
					if (seq_q == SEQ_S03) seq_ok = SEQ_K04;
					else if (seq_q == SEQ_S05) seq_code = sas_pkg::NRC_RANGE;
					else seq_code = sas_pkg::NRC_SEQUENCE;
				end
				sas_pkg::SF_SEED_B: begin
					if (seq_q == SEQ_IDLE || seq_q == SEQ_S05) seq_ok = SEQ_S05;
					else seq_code = sas_pkg::NRC_SEQUENCE;
				end
				sas_pkg::SF_KEY_B: begin
					if (seq_q == SEQ_S05) seq_ok = SEQ_K06;
					else if (seq_q == SEQ_S03) seq_code = sas_pkg::NRC_RANGE;
					else seq_code = sas_pkg::NRC_SEQUENCE;
				end
				sas_pkg::SF_SEED_C: begin
					if (seq_q == SEQ_IDLE || seq_q == SEQ_S11) seq_ok = SEQ_S11;
					else seq_code = sas_pkg::NRC_SEQUENCE;
				end
				default: begin
					if (seq_q == SEQ_S11) seq_ok = SEQ_K12;
					else seq_code = sas_pkg::NRC_SEQUENCE;
				end
			endcase
		end
	end

	// Next state and reply for the item in the input register.
	always_comb begin
		seq_d    = seq_q;
		seed_d   = seed_q;
		level_d  = level_q;
		fail_d   = fail_q;
		lock_d   = lock_q;
		remain_d = remain_q;

		reply.reply_kind         = sas_pkg::KIND_NONE;
		reply.negative_code      = sas_pkg::NRC_NONE;
		reply.reply_sub_function = 8'd0;
		reply.has_seed           = 1'b0;
		reply.seed_out           = 32'd0;

		case (item.cmd)
			sas_pkg::CMD_REQUEST: begin
				reply.reply_kind = sas_pkg::KIND_NEGATIVE;
				if (item.msg_length < sas_pkg::LEN_MIN) begin
					reply.negative_code = sas_pkg::NRC_LENGTH;
				end else if (is_seed && item.msg_length != sas_pkg::LEN_SEED) begin
					reply.negative_code = sas_pkg::NRC_LENGTH;
				end else if (is_key && item.msg_length != sas_pkg::LEN_KEY) begin
					reply.negative_code = sas_pkg::NRC_LENGTH;
				end else if (!is_seed && !is_key) begin
					reply.negative_code = sas_pkg::NRC_SUBFUNC;
				end else if (seq_code != sas_pkg::NRC_NONE) begin
					reply.negative_code = seq_code;
				end else if (is_seed) begin
					if ({3'd0, level_q} == sub) begin
						// Level already open: positive reply with an all-zero seed.
						seq_d                    = SEQ_IDLE;
						reply.reply_kind         = sas_pkg::KIND_POSITIVE;
						reply.reply_sub_function = sub;
						reply.has_seed           = 1'b1;
					end else if (lock_q) begin
						seq_d               = SEQ_DELAY;
						reply.negative_code = sas_pkg::NRC_DELAY;
					end else begin
						seq_d                    = seq_ok;
						seed_d                   = item.fresh_seed;
						reply.reply_kind         = sas_pkg::KIND_POSITIVE;
						reply.reply_sub_function = sub;
						reply.has_seed           = 1'b1;
						reply.seed_out           = item.fresh_seed;
					end
				end else if (lock_q) begin
					seq_d               = SEQ_DELAY;
					reply.negative_code = sas_pkg::NRC_DELAY;
				end else begin
					seq_d = SEQ_IDLE;
					if (item.expected_key != item.key_received) begin
						fail_d  = fail_inc;
						level_d = sas_pkg::LVL_LOCKED;
						if (fail_inc >= cfg.max_attempts) begin
							lock_d              = 1'b1;
							remain_d            = cfg.lockout_ticks;
							reply.negative_code = sas_pkg::NRC_ATTEMPTS;
						end else begin
							reply.negative_code = sas_pkg::NRC_BADKEY;
						end
					end else begin
						level_d                  = 5'(sub - 8'd1);
						reply.reply_kind         = sas_pkg::KIND_POSITIVE;
						reply.reply_sub_function = sub;
					end
				end
			end
			sas_pkg::CMD_TICK: begin
				if (lock_q) begin
					if (remain_q <= 16'd1) begin
						lock_d   = 1'b0;
						remain_d = 16'd0;
						fail_d   = 4'd0;
						seq_d    = SEQ_IDLE;
					end else begin
						remain_d = remain_q - 16'd1;
					end
				end
			end
			sas_pkg::CMD_SESSION: begin
				seq_d    = SEQ_IDLE;
				seed_d   = 32'd0;
				level_d  = sas_pkg::LVL_LOCKED;
				fail_d   = 4'd0;
				lock_d   = 1'b0;
				remain_d = 16'd0;
			end
			default: begin
			end
		endcase

		reply.unlocked_level = level_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= SEQ_IDLE;
			seed_q   <= 32'd0;
			level_q  <= sas_pkg::LVL_LOCKED;
			fail_q   <= 4'd0;
			lock_q   <= 1'b0;
			remain_q <= 16'd0;
		end else if (step_en) begin
			seq_q    <= seq_d;
			seed_q   <= seed_d;
			level_q  <= level_d;
			fail_q   <= fail_d;
			lock_q   <= lock_d;
			remain_q <= remain_d;
		end
	end

	assign level_legal   = (level_q == sas_pkg::LVL_LOCKED) || (level_q == sas_pkg::LVL_A) ||
	                       (level_q == sas_pkg::LVL_B) || (level_q == sas_pkg::LVL_C);
	assign lock_entry_ok = (level_q == sas_pkg::LVL_LOCKED) && (seq_q == SEQ_IDLE);
	assign non_request   = step_en && (item.cmd != sas_pkg::CMD_REQUEST);
	assign quiet_reply   = (reply.reply_kind == sas_pkg::KIND_NONE);

	`SAS_ASSERT(a_idle_count_clear, lock_q || remain_q == 16'd0, "lockout count while unlocked")
	`SAS_ASSERT(a_delay_needs_lock, seq_q != SEQ_DELAY || lock_q, "delay step without lockout")
	`SAS_ASSERT(a_level_legal, level_legal, "illegal level")
	`SAS_ASSERT(a_lock_relocks, $rose(lock_q) |-> lock_entry_ok, "lockout began with level open")
	`SAS_ASSERT(a_no_reply_cmd, non_request |-> quiet_reply, "reply to a non-request")

endmodule

>>> src/security_access_sequencer.sv
`timescale 1ns / 1ps

// Channel   Signals                          Direction  Carries
// item      item_valid, item_ready, item     in         one request, tick or session change
// result    result_valid, result_ready, result out      one reply per item
// config    cfg_valid, cfg_ready, cfg_index,  in         register writes, always ready
//           cfg_data
//
// One item is taken per clock cycle while the result side is not stalled;
// every item gives exactly one result, held first in the input register and
// then in the result register. The session state (sequence, level, failure
// count, lockout counter) is updated as an item moves between the two registers.
// Reset clears the session state and restores max_attempts to 3 and
// lockout_ticks to 10000. A stalled result side fills both registers and then
// holds item_ready low; no item is lost or taken twice.

module security_access_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  sas_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output sas_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sas_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sas_pkg::CFG_DATA_W-1:0]    cfg_data
);

	sas_pkg::item_t   item_s1;
	logic             vld_s1;
	sas_pkg::result_t res_s2;
	logic             vld_s2;
	sas_pkg::result_t reply;
	sas_pkg::cfg_t    cfg;
	logic             advance;

	// The item in the input register moves on when the result register is
	// empty or its content leaves in this same cycle.
	assign advance    = vld_s1 && (!vld_s2 || result_ready);
	assign item_ready = !vld_s1 || advance;
	assign cfg_ready  = 1'b1;

	sas_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The session state is updated only when an item passes into the result
	// register, so state and replies follow item order exactly.
	sas_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.reply   (reply)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (item_ready) vld_s1 <= item_valid;
			if (advance) vld_s2 <= 1'b1;
			else if (result_ready) vld_s2 <= 1'b0;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) item_s1 <= item;
		if (advance) res_s2 <= reply;
	end

	assign result_valid = vld_s2;
	assign result       = res_s2;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

// Testbench for the security access sequencer.
//
// Requests, ticks and session changes go in through the item channel; every
// transfer there is run through a predictor of the session state kept in this
// file, and the reply it yields is queued. Each reply transfer on the result
// channel is checked field by field against the oldest queued reply.
//
// The run is a directed pass over the request checks and the seed and key
// sequence, then a directed pass over the bad key lockout, and then random
// traffic under six register settings. Each setting goes through four idling
// patterns: no idling, an idle sender, a stalling receiver, and both at once.

module testbench;

	// Codes that the package leaves unnamed: the command that the block
	// ignores and a register index with no register behind it.
	localparam logic [1:0]                    CMD_SPARE = 2'd3;
	localparam logic [sas_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// Quiet after the last reply owed, before a register write or the end of the
	// run, leaves a margin.
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES    = 8;
	// Cycles without any transfer on any channel before the run is given up.
	localparam int STALL_LIMIT   = 2000;
	localparam int REPORT_LIMIT  = 10;
	localparam int PHASES        = 6;
	localparam int ITEMS_PER_MIX = 63;

	// Where the predictor stands in the seed and key sequence.
	typedef enum logic [2:0] {
		STEP_IDLE,
		STEP_SEED_A,
		STEP_KEY_A,
		STEP_SEED_B,
		STEP_KEY_B,
		STEP_SEED_C,
		STEP_KEY_C,
		STEP_DELAY
	} step_t;

	logic                           clk;
	logic                           arst_n;
	logic                           item_valid;
	logic                           item_ready;
	sas_pkg::item_t                 item;
	logic                           result_valid;
	logic                           result_ready;
	sas_pkg::result_t               result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [sas_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sas_pkg::CFG_DATA_W-1:0] cfg_data;

	security_access_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Predictor copy of the registers and of the session state.
	logic [3:0]  cur_max_attempts;
	logic [15:0] cur_lockout_ticks;
	step_t       step;
	logic [4:0]  level;
	logic [3:0]  fail_count;
	logic        lock_on;
	logic [15:0] lock_left;

	// Replies that the block owes, oldest first.
	sas_pkg::result_t replies_due [$];

	int          faults = 0;
	int          replies_seen = 0;
	int unsigned quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;

	// Idling patterns, and the register settings of the random phases. The
	// largest and the smallest nonzero values of both registers are among them.
	int          mix_send_idle [4] = '{0, 82, 0, 25};
	int          mix_stall [4]     = '{0, 0, 82, 25};
	logic [3:0]  phase_max [PHASES]   = '{4'd1, 4'd15, 4'd2, 4'd5, 4'd3, 4'd1};
	logic [15:0] phase_ticks [PHASES] = '{16'd1, 16'd65535, 16'd3, 16'd20, 16'd7, 16'd2};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver decides afresh at every falling edge whether to take a reply.
	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic void show_reply(input string tag, input int n,
			input sas_pkg::result_t r);
		$display("reply %0d mismatch, %s kind %0d code %0d sub %h seed %b/%h level %0d",
			n, tag, r.reply_kind, r.negative_code, r.reply_sub_function, r.has_seed,
			r.seed_out, r.unlocked_level);
	endfunction

	// Reply checker: every result transfer is compared with the oldest reply owed.
	always @(posedge clk) begin : check_replies
		sas_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			replies_seen++;
			if (replies_due.size() == 0) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("reply %0d arrived with none owed: kind %0d code %0d",
						replies_seen, result.reply_kind, result.negative_code);
			end else begin
				want = replies_due.pop_front();
				if (result.reply_kind !== want.reply_kind
						|| result.negative_code !== want.negative_code
						|| result.reply_sub_function !== want.reply_sub_function
						|| result.has_seed !== want.has_seed
						|| result.seed_out !== want.seed_out
						|| result.unlocked_level !== want.unlocked_level) begin
					faults++;
					if (faults <= REPORT_LIMIT) begin
						show_reply("expected:", replies_seen, want);
						show_reply("actual:  ", replies_seen, result);
					end
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no transfer anywhere means a hang.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// A session change and a reset both drop the whole session state.
	task automatic clear_session();
		step = STEP_IDLE;
		level = sas_pkg::LVL_LOCKED;
		fail_count = '0;
		lock_on = 1'b0;
		lock_left = '0;
	endtask

	// Works out the reply to one item and moves the session state on.
	task automatic predict_reply(input sas_pkg::item_t it, output sas_pkg::result_t r);
		logic       is_seed;
		logic       is_key;
		logic [2:0] code;
		r = '0;
		code = sas_pkg::NRC_NONE;
		is_seed = (it.sub_function == sas_pkg::SF_SEED_A)
			|| (it.sub_function == sas_pkg::SF_SEED_B)
			|| (it.sub_function == sas_pkg::SF_SEED_C);
		is_key = (it.sub_function == sas_pkg::SF_KEY_A)
			|| (it.sub_function == sas_pkg::SF_KEY_B)
			|| (it.sub_function == sas_pkg::SF_KEY_C);
		case (it.cmd)
			sas_pkg::CMD_REQUEST: begin
				// Length comes first, even ahead of an unknown sub-function.
				if (it.msg_length < sas_pkg::LEN_MIN)
					code = sas_pkg::NRC_LENGTH;
				else if (is_seed)
					code = (it.msg_length != sas_pkg::LEN_SEED) ? sas_pkg::NRC_LENGTH
						: sas_pkg::NRC_NONE;
				else if (is_key)
					code = (it.msg_length != sas_pkg::LEN_KEY) ? sas_pkg::NRC_LENGTH
						: sas_pkg::NRC_NONE;
				else
					code = sas_pkg::NRC_SUBFUNC;

				// Sequence check. A seed request may repeat its own level; a key
				// must follow its own seed, and a key of the other low level is
				// an out of range request rather than a sequence error.
				if (code == sas_pkg::NRC_NONE && step == STEP_DELAY) begin
					code = sas_pkg::NRC_DELAY;
				end else if (code == sas_pkg::NRC_NONE) begin
					case (it.sub_function)
						sas_pkg::SF_SEED_A: begin
							if (step == STEP_IDLE || step == STEP_SEED_A) step = STEP_SEED_A;
							else code = sas_pkg::NRC_SEQUENCE;
						end
						sas_pkg::SF_KEY_A: begin
							if (step == STEP_SEED_A) step = STEP_KEY_A;
							else if (step == STEP_SEED_B) code = sas_pkg::NRC_RANGE;
							else code = sas_pkg::NRC_SEQUENCE;
						end
						sas_pkg::SF_SEED_B: begin
							if (step == STEP_IDLE || step == STEP_SEED_B) step = STEP_SEED_B;
							else code = sas_pkg::NRC_SEQUENCE;
						end
						sas_pkg::SF_KEY_B: begin
							if (step == STEP_SEED_B) step = STEP_KEY_B;
							else if (step == STEP_SEED_A) code = sas_pkg::NRC_RANGE;
							else code = sas_pkg::NRC_SEQUENCE;
						end
						sas_pkg::SF_SEED_C: begin
							if (step == STEP_IDLE || step == STEP_SEED_C) step = STEP_SEED_C;
							else code = sas_pkg::NRC_SEQUENCE;
						end
						default: begin
							if (step == STEP_SEED_C) step = STEP_KEY_C;
							else code = sas_pkg::NRC_SEQUENCE;
						end
					endcase
				end

				if (code != sas_pkg::NRC_NONE) begin
					r.reply_kind = sas_pkg::KIND_NEGATIVE;
					r.negative_code = code;
				end else if (is_seed && {3'b000, level} == it.sub_function) begin
					// Level already open: a zero seed, and back to idle.
					step = STEP_IDLE;
					r.reply_kind = sas_pkg::KIND_POSITIVE;
					r.reply_sub_function = it.sub_function;
					r.has_seed = 1'b1;
				end else if (lock_on) begin
					step = STEP_DELAY;
					r.reply_kind = sas_pkg::KIND_NEGATIVE;
					r.negative_code = sas_pkg::NRC_DELAY;
				end else if (is_seed) begin
					r.reply_kind = sas_pkg::KIND_POSITIVE;
					r.reply_sub_function = it.sub_function;
					r.has_seed = 1'b1;
					r.seed_out = it.fresh_seed;
				end else begin
					step = STEP_IDLE;
					if (it.expected_key != it.key_received) begin
						// Bad keys pile up and are not cleared by a good one.
						if (fail_count != sas_pkg::FAIL_MAX)
							fail_count++;
						level = sas_pkg::LVL_LOCKED;
						r.reply_kind = sas_pkg::KIND_NEGATIVE;
						if (fail_count >= cur_max_attempts) begin
							lock_on = 1'b1;
							lock_left = cur_lockout_ticks;
							r.negative_code = sas_pkg::NRC_ATTEMPTS;
						end else begin
							r.negative_code = sas_pkg::NRC_BADKEY;
						end
					end else begin
						level = it.sub_function[4:0] - 5'd1;
						r.reply_kind = sas_pkg::KIND_POSITIVE;
						r.reply_sub_function = it.sub_function;
					end
				end
			end
			sas_pkg::CMD_TICK: begin
				if (lock_on) begin
					if (lock_left <= 16'd1) begin
						lock_on = 1'b0;
						lock_left = '0;
						fail_count = '0;
						step = STEP_IDLE;
					end else begin
						lock_left--;
					end
				end
			end
			sas_pkg::CMD_SESSION: begin
				clear_session();
			end
			default: ;
		endcase
		r.unlocked_level = level;
	endtask

	function automatic sas_pkg::item_t request(input logic [7:0] len, input logic [7:0] sub,
			input logic [31:0] key, input logic [31:0] want_key, input logic [31:0] seed);
		sas_pkg::item_t it;
		it.cmd = sas_pkg::CMD_REQUEST;
		it.msg_length = len;
		it.sub_function = sub;
		it.key_received = key;
		it.expected_key = want_key;
		it.fresh_seed = seed;
		return it;
	endfunction

	// Ticks, session changes and the spare command; the rest of the item is noise.
	function automatic sas_pkg::item_t control(input logic [1:0] cmd);
		sas_pkg::item_t it;
		it.cmd = cmd;
		it.msg_length = 8'($urandom);
		it.sub_function = 8'($urandom);
		it.key_received = $urandom;
		it.expected_key = $urandom;
		it.fresh_seed = $urandom;
		return it;
	endfunction

	// Offers one item, idling first at the current rate, and books the reply
	// once the transfer has taken place. Valid stays high on return, so the
	// next call can follow on without a gap.
	task automatic send_item(input sas_pkg::item_t it);
		sas_pkg::result_t want;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		predict_reply(it, want);
		replies_due.push_back(want);
	endtask

	// Withdraws the item channel and waits for every reply owed, plus a margin.
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sas_pkg::CFG_IDX_W-1:0] idx,
			input logic [sas_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			sas_pkg::CFG_MAX_ATTEMPTS:  cur_max_attempts = data[3:0];
			sas_pkg::CFG_LOCKOUT_TICKS: cur_lockout_ticks = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Both registers, written once the block has gone quiet. The unused upper
	// bits of the attempt limit carry noise.
	task automatic configure(input logic [3:0] attempts, input logic [15:0] ticks);
		logic [31:0] word;
		wait_idle();
		word = $urandom;
		word[3:0] = attempts;
		write_reg(sas_pkg::CFG_MAX_ATTEMPTS, word[15:0]);
		write_reg(sas_pkg::CFG_LOCKOUT_TICKS, ticks);
	endtask

	// Length and sub-function checks, sequence and out of range errors, seeds
	// and unlocks of all three levels, a bad key, and the non-request commands.
	task automatic test_request_checks();
		sas_pkg::item_t it;
		logic [31:0]    key;
		send_item(request(8'd0, sas_pkg::SF_SEED_A, '0, '0, '0));
		send_item(request(8'd1, 8'hFF, '1, '1, '1));
		send_item(request(8'hFF, sas_pkg::SF_SEED_A, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_KEY_A, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_SEED, 8'h00, '0, '0, '0));
		send_item(request(8'hFF, 8'hFF, '1, '1, '1));
		// A key with no seed before it.
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_A, '0, '0, $urandom));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_B, $urandom, $urandom, '1));
		// The wrong key for the seed just given is out of range.
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_A, $urandom, $urandom, $urandom));
		key = $urandom;
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_B, key, key, $urandom));
		// The level is open now, so its seed comes back as zero.
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_B, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_A, $urandom, $urandom, '0));
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_B, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_A, '1, '0, $urandom));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_C, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_C, $urandom, $urandom, $urandom));
		key = $urandom;
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_C, key, key, $urandom));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_A, $urandom, $urandom, $urandom));
		// A seed of another level in the middle of a sequence.
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_B, $urandom, $urandom, $urandom));
		send_item(control(sas_pkg::CMD_TICK));
		send_item(control(sas_pkg::CMD_SESSION));
		it = '1;
		it.cmd = CMD_SPARE;
		send_item(it);
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_A, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_A, '0, '0, $urandom));
	endtask

	// Lockout after too many bad keys: requests during the lockout are turned
	// away with a delay code, and ticks bring the block back.
	task automatic test_lockout();
		configure(4'd1, 16'd1);
		send_item(control(sas_pkg::CMD_SESSION));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_A, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_A, 32'h1, 32'h2, $urandom));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_A, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_A, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_SEED, 8'h00, $urandom, $urandom, $urandom));
		send_item(control(sas_pkg::CMD_TICK));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_A, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_A, 32'h5, 32'h5, $urandom));

		configure(4'd2, 16'd3);
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_B, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_B, 32'h0, 32'hFFFF_FFFF, $urandom));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_B, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_B, 32'h0, 32'hFFFF_FFFF, $urandom));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_C, $urandom, $urandom, $urandom));
		send_item(control(sas_pkg::CMD_TICK));
		send_item(control(sas_pkg::CMD_TICK));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_C, $urandom, $urandom, $urandom));
		send_item(control(sas_pkg::CMD_TICK));
		send_item(request(sas_pkg::LEN_SEED, sas_pkg::SF_SEED_C, $urandom, $urandom, $urandom));
		send_item(request(sas_pkg::LEN_KEY, sas_pkg::SF_KEY_C, 32'h7, 32'h7, $urandom));
		send_item(control(sas_pkg::CMD_SESSION));
	endtask

	// Mostly well formed seed and key pairs with random keys, so that unlocks,
	// bad keys and lockouts all come round; the rest is tick bursts, session
	// changes, noise and requests that break the sequence.
	task automatic random_traffic(input int count);
		sas_pkg::item_t it;
		int             sent;
		int             pick;
		int             burst;
		logic [7:0]     seed_sf;
		logic [31:0]    key;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			case ($urandom_range(2))
				0: seed_sf = sas_pkg::SF_SEED_A;
				1: seed_sf = sas_pkg::SF_SEED_B;
				default: seed_sf = sas_pkg::SF_SEED_C;
			endcase
			if (pick < 55) begin
				send_item(request(sas_pkg::LEN_SEED, seed_sf, $urandom, $urandom, $urandom));
				sent++;
				if ($urandom_range(9) == 0) begin
					send_item(request(sas_pkg::LEN_SEED, seed_sf, $urandom, $urandom,
						$urandom));
					sent++;
				end
				if ($urandom_range(9) != 0) begin
					key = $urandom;
					send_item(request(sas_pkg::LEN_KEY, seed_sf + 8'd1, key,
						($urandom_range(99) < 55) ? key : $urandom, $urandom));
					sent++;
				end
			end else if (pick < 70) begin
				burst = $urandom_range(6, 1);
				repeat (burst) send_item(control(sas_pkg::CMD_TICK));
				sent += burst;
			end else if (pick < 74) begin
				send_item(control(sas_pkg::CMD_SESSION));
				sent++;
			end else if (pick < 76) begin
				// Ignored by the block, so not counted.
				send_item(control(CMD_SPARE));
			end else if (pick < 86) begin
				it = control(sas_pkg::CMD_REQUEST);
				send_item(it);
				sent++;
			end else begin
				// A known sub-function, key or seed, with a length that is
				// sometimes right and sometimes not.
				if ($urandom_range(1) == 1)
					seed_sf = seed_sf + 8'd1;
				case ($urandom_range(4))
					0: it = request(8'd1, seed_sf, $urandom, $urandom, $urandom);
					1: it = request(sas_pkg::LEN_SEED, seed_sf, $urandom, $urandom, $urandom);
					2: it = request(sas_pkg::LEN_KEY, seed_sf, $urandom, $urandom, $urandom);
					3: it = request(8'd7, seed_sf, $urandom, $urandom, $urandom);
					default: it = request(8'($urandom), seed_sf, $urandom, $urandom,
						$urandom);
				endcase
				if ($urandom_range(1) == 1)
					it.expected_key = it.key_received;
				send_item(it);
				sent++;
			end
		end
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < PHASES; p++) begin
			configure(phase_max[p], phase_ticks[p]);
			// A write to an index with no register behind it changes nothing.
			if (p == 0)
				write_reg(CFG_SPARE, 16'($urandom));
			for (int m = 0; m < 4; m++) begin
				send_idle_pct = mix_send_idle[m];
				stall_pct = mix_stall[m];
				random_traffic(ITEMS_PER_MIX);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_max_attempts = sas_pkg::MAX_ATTEMPTS_RST;
		cur_lockout_ticks = sas_pkg::LOCKOUT_TICKS_RST;
		clear_session();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_request_checks();
		test_lockout();
		test_random_phases();

		wait_idle();
		repeat (END_CYCLES) @(posedge clk);
		faults += replies_due.size();
		if (faults == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
